// ===== src/fcu_pkg.sv =====
// ----------------------------------------------------------------------------
// fcu_pkg: shared definitions for the fly camera update block
// Codes, command and status structs, fixed-point constants and tables.
// ----------------------------------------------------------------------------
`default_nettype none

package fcu_pkg;

	// Angle constants, Q9.6 degrees
	localparam int FULL_TURN    = 23040;
	localparam int HALF_TURN    = 11520;
	localparam int QUARTER_TURN = 5760;
	localparam int PITCH_LIMIT  = 5696;
	localparam int ONE_Q14      = 16384;

	// Sine series coefficients, Q2.30
	localparam logic [31:0] C1 = 32'd1686629713;
	localparam logic [31:0] C3 = 32'd693598668;
	localparam logic [31:0] C5 = 32'd85569306;
	localparam logic [31:0] C7 = 32'd5026995;
	localparam logic [31:0] C9 = 32'd172272;

	// Quarter wave a -> x = a * 2^30 / 5760 = a * 2^23 / 45, split a = 45 q + r
	localparam int          QUOT_DIV   = 45;
	localparam logic [14:0] QUOT_RECIP = 15'd23302;   // ceil(2^20 / 45)
	// Yaw wrap: floor(u / 23040) = floor((u >> 9) / 45)
	localparam logic [19:0] WRAP_RECIP  = 20'd745655; // ceil(2^25 / 45)
	localparam logic [27:0] WRAP_OFFSET = 28'd94371840; // 4096 full turns

	// Register indexes
	localparam logic REG_MOVE_SPEED = 1'b0;
	localparam logic REG_LOOK_GAIN  = 1'b1;

	// Move codes
	localparam logic [2:0] MV_FORWARD  = 3'd0;
	localparam logic [2:0] MV_BACKWARD = 3'd1;
	localparam logic [2:0] MV_RIGHT    = 3'd2;
	localparam logic [2:0] MV_LEFT     = 3'd3;
	localparam logic [2:0] MV_UP       = 3'd4;
	localparam logic [2:0] MV_DOWN     = 3'd5;

	localparam logic MODE_MOVE = 1'b0;
	localparam logic MODE_LOOK = 1'b1;

	// Trig slots
	localparam logic [1:0] TRIG_SY = 2'd0;
	localparam logic [1:0] TRIG_CY = 2'd1;
	localparam logic [1:0] TRIG_SP = 2'd2;
	localparam logic [1:0] TRIG_CP = 2'd3;

	// Multiplier operand selects
	typedef logic [3:0] mul_sel_t;
	localparam mul_sel_t MUL_NONE   = 4'd0;
	localparam mul_sel_t MUL_DIST   = 4'd1;
	localparam mul_sel_t MUL_DYAW   = 4'd2;
	localparam mul_sel_t MUL_DPITCH = 4'd3;
	localparam mul_sel_t MUL_WRAP   = 4'd4;
	localparam mul_sel_t MUL_QUOT   = 4'd5;
	localparam mul_sel_t MUL_XX     = 4'd6;
	localparam mul_sel_t MUL_HORNER = 4'd7;
	localparam mul_sel_t MUL_XP     = 4'd8;
	localparam mul_sel_t MUL_STEP   = 4'd9;
	localparam mul_sel_t MUL_DIR0   = 4'd10;
	localparam mul_sel_t MUL_DIR2   = 4'd11;

	// Write-back selects
	typedef logic [3:0] wb_sel_t;
	localparam wb_sel_t WB_NONE   = 4'd0;
	localparam wb_sel_t WB_DIST   = 4'd1;
	localparam wb_sel_t WB_YAW    = 4'd2;
	localparam wb_sel_t WB_WRAP   = 4'd3;
	localparam wb_sel_t WB_PITCH  = 4'd4;
	localparam wb_sel_t WB_SLOAD  = 4'd5;
	localparam wb_sel_t WB_QUOT   = 4'd6;
	localparam wb_sel_t WB_X2     = 4'd7;
	localparam wb_sel_t WB_HORNER = 4'd8;
	localparam wb_sel_t WB_SIN    = 4'd9;
	localparam wb_sel_t WB_STEP   = 4'd10;
	localparam wb_sel_t WB_VERT   = 4'd11;
	localparam wb_sel_t WB_DIR0   = 4'd12;
	localparam wb_sel_t WB_DIR2   = 4'd13;

	typedef struct packed {
		logic     load;
		logic     publish;
		mul_sel_t mul_sel;
		wb_sel_t  wb_sel;
		logic [1:0] idx;
	} fcu_cmd_t;

	typedef struct packed {
		logic       mode;
		logic [2:0] move_dir;
	} fcu_stat_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic signed [15:0] dir_z;
		logic signed [14:0] yaw_deg;
		logic signed [13:0] pitch_deg;
	} fcu_state_t;

	// floor(r * 2^23 / 45) for each remainder r
	typedef logic [22:0] xfrac_t [0:QUOT_DIV-1];

	function automatic xfrac_t build_xfrac();
		xfrac_t t;
		for (int i = 0; i < QUOT_DIV; i++) begin
			t[i] = 23'((64'(i) << 23) / QUOT_DIV);
		end
		return t;
	endfunction

	localparam xfrac_t XFRAC = build_xfrac();

	// Horner coefficient for step k
	function automatic logic [31:0] hcoef(input logic [1:0] k);
		logic [31:0] c;
		case (k)
			2'd0:    c = C7;
			2'd1:    c = C5;
			2'd2:    c = C3;
			default: c = C1;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== src/fcu_ctrl.sv =====
// ----------------------------------------------------------------------------
// fcu_ctrl: sequencer for the fly camera update
// Steps the shared multiplier and write-back selects through each request.
// ----------------------------------------------------------------------------
`default_nettype none

module fcu_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              out_free,
	input  wire fcu_pkg::fcu_stat_t stat,
	output fcu_pkg::fcu_cmd_t      cmd
);

	localparam logic [4:0] S_IDLE     = 5'd0;
	localparam logic [4:0] S_DISPATCH = 5'd1;
	localparam logic [4:0] S_MV_DM    = 5'd2;
	localparam logic [4:0] S_MV_DW    = 5'd3;
	localparam logic [4:0] S_MV_VERT  = 5'd4;
	localparam logic [4:0] S_MV_SM    = 5'd5;
	localparam logic [4:0] S_MV_SW    = 5'd6;
	localparam logic [4:0] S_LK_YM    = 5'd7;
	localparam logic [4:0] S_LK_YW    = 5'd8;
	localparam logic [4:0] S_LK_WM    = 5'd9;
	localparam logic [4:0] S_LK_WW    = 5'd10;
	localparam logic [4:0] S_LK_PM    = 5'd11;
	localparam logic [4:0] S_LK_PW    = 5'd12;
	localparam logic [4:0] S_SN_LOAD  = 5'd13;
	localparam logic [4:0] S_SN_QM    = 5'd14;
	localparam logic [4:0] S_SN_QW    = 5'd15;
	localparam logic [4:0] S_SN_XM    = 5'd16;
	localparam logic [4:0] S_SN_XW    = 5'd17;
	localparam logic [4:0] S_SN_HM    = 5'd18;
	localparam logic [4:0] S_SN_HW    = 5'd19;
	localparam logic [4:0] S_SN_RM    = 5'd20;
	localparam logic [4:0] S_SN_RW    = 5'd21;
	localparam logic [4:0] S_LK_D0M   = 5'd22;
	localparam logic [4:0] S_LK_D0W   = 5'd23;
	localparam logic [4:0] S_LK_D2M   = 5'd24;
	localparam logic [4:0] S_LK_D2W   = 5'd25;
	localparam logic [4:0] S_DONE     = 5'd26;

	logic [4:0] state_q, state_d;
	logic [1:0] idx_q, idx_d;   // axis or trig slot
	logic [1:0] k_q, k_d;       // Horner step
	logic       sin_last;

	assign in_ready = (state_q == S_IDLE);
	assign sin_last = (stat.mode == fcu_pkg::MODE_LOOK) ? (idx_q == fcu_pkg::TRIG_CP)
		: (idx_q == fcu_pkg::TRIG_CY);

	// Next state and command decode
	always_comb begin
		state_d     = state_q;
		idx_d       = idx_q;
		k_d         = k_q;
		cmd.load    = 1'b0;
		cmd.publish = 1'b0;
		cmd.mul_sel = fcu_pkg::MUL_NONE;
		cmd.wb_sel  = fcu_pkg::WB_NONE;
		cmd.idx     = idx_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (stat.mode == fcu_pkg::MODE_LOOK) state_d = S_LK_YM;
				else if (stat.move_dir > fcu_pkg::MV_DOWN) state_d = S_DONE;
				else state_d = S_MV_DM;
			end
			S_MV_DM: begin
				cmd.mul_sel = fcu_pkg::MUL_DIST;
				state_d     = S_MV_DW;
			end
			S_MV_DW: begin
				cmd.wb_sel = fcu_pkg::WB_DIST;
				idx_d      = 2'd0;
				if (stat.move_dir == fcu_pkg::MV_UP || stat.move_dir == fcu_pkg::MV_DOWN)
					state_d = S_MV_VERT;
				else if (stat.move_dir == fcu_pkg::MV_RIGHT ||
					stat.move_dir == fcu_pkg::MV_LEFT)
					state_d = S_SN_LOAD;
				else state_d = S_MV_SM;
			end
			S_MV_VERT: begin
				cmd.wb_sel = fcu_pkg::WB_VERT;
				state_d    = S_DONE;
			end
			S_MV_SM: begin
				cmd.mul_sel = fcu_pkg::MUL_STEP;
				state_d     = S_MV_SW;
			end
			S_MV_SW: begin
				cmd.wb_sel = fcu_pkg::WB_STEP;
				if (idx_q == 2'd2) begin
					state_d = S_DONE;
				end else begin
					idx_d   = idx_q + 2'd1;
					state_d = S_MV_SM;
				end
			end
			S_LK_YM: begin
				cmd.mul_sel = fcu_pkg::MUL_DYAW;
				state_d     = S_LK_YW;
			end
			S_LK_YW: begin
				cmd.wb_sel = fcu_pkg::WB_YAW;
				state_d    = S_LK_WM;
			end
			S_LK_WM: begin
				cmd.mul_sel = fcu_pkg::MUL_WRAP;
				state_d     = S_LK_WW;
			end
			S_LK_WW: begin
				cmd.wb_sel = fcu_pkg::WB_WRAP;
				state_d    = S_LK_PM;
			end
			S_LK_PM: begin
				cmd.mul_sel = fcu_pkg::MUL_DPITCH;
				state_d     = S_LK_PW;
			end
			S_LK_PW: begin
				cmd.wb_sel = fcu_pkg::WB_PITCH;
				idx_d      = fcu_pkg::TRIG_SY;
				state_d    = S_SN_LOAD;
			end
			S_SN_LOAD: begin
				cmd.wb_sel = fcu_pkg::WB_SLOAD;
				state_d    = S_SN_QM;
			end
			S_SN_QM: begin
				cmd.mul_sel = fcu_pkg::MUL_QUOT;
				state_d     = S_SN_QW;
			end
			S_SN_QW: begin
				cmd.wb_sel = fcu_pkg::WB_QUOT;
				state_d    = S_SN_XM;
			end
			S_SN_XM: begin
				cmd.mul_sel = fcu_pkg::MUL_XX;
				state_d     = S_SN_XW;
			end
			S_SN_XW: begin
				cmd.wb_sel = fcu_pkg::WB_X2;
				k_d        = 2'd0;
				state_d    = S_SN_HM;
			end
			S_SN_HM: begin
				cmd.mul_sel = fcu_pkg::MUL_HORNER;
				state_d     = S_SN_HW;
			end
			S_SN_HW: begin
				cmd.wb_sel = fcu_pkg::WB_HORNER;
				cmd.idx    = k_q;
				k_d        = k_q + 2'd1;
				state_d    = (k_q == 2'd3) ? S_SN_RM : S_SN_HM;
			end
			S_SN_RM: begin
				cmd.mul_sel = fcu_pkg::MUL_XP;
				state_d     = S_SN_RW;
			end
			S_SN_RW: begin
				cmd.wb_sel = fcu_pkg::WB_SIN;
				if (!sin_last) begin
					idx_d   = idx_q + 2'd1;
					state_d = S_SN_LOAD;
				end else if (stat.mode == fcu_pkg::MODE_LOOK) begin
					state_d = S_LK_D0M;
				end else begin
					idx_d   = 2'd0;
					state_d = S_MV_SM;
				end
			end
			S_LK_D0M: begin
				cmd.mul_sel = fcu_pkg::MUL_DIR0;
				state_d     = S_LK_D0W;
			end
			S_LK_D0W: begin
				cmd.wb_sel = fcu_pkg::WB_DIR0;
				state_d    = S_LK_D2M;
			end
			S_LK_D2M: begin
				cmd.mul_sel = fcu_pkg::MUL_DIR2;
				state_d     = S_LK_D2W;
			end
			S_LK_D2W: begin
				cmd.wb_sel = fcu_pkg::WB_DIR2;
				state_d    = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					cmd.publish = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Hold state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= 2'd0;
			k_q     <= 2'd0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			k_q     <= k_d;
		end
	end

endmodule

`default_nettype wire

// ===== src/fcu_dp.sv =====
// ----------------------------------------------------------------------------
// fcu_dp: datapath for the fly camera update
// Config registers, camera state, one shared registered multiplier and the
// write-back logic for distance, angle wrap, sine series and position steps.
// ----------------------------------------------------------------------------
`default_nettype none

module fcu_dp (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic               cfg_index,
	input  wire logic [15:0]        cfg_data,
	input  wire logic               in_mode,
	input  wire logic [2:0]         in_move_dir,
	input  wire logic [15:0]        in_elapsed_ms,
	input  wire logic signed [15:0] in_mouse_dx,
	input  wire logic signed [15:0] in_mouse_dy,
	input  wire fcu_pkg::fcu_cmd_t  cmd,
	output fcu_pkg::fcu_stat_t      stat,
	output fcu_pkg::fcu_state_t     st
);

	// Config
	logic [15:0] speed_q, gain_q;
	// Latched request
	logic              mode_q;
	logic [2:0]        dir_q;
	logic [15:0]       elapsed_q;
	logic signed [15:0] dx_q, dy_q;
	// Camera state
	logic signed [31:0] pos_q [0:2];
	logic signed [15:0] vdir_q [0:2];
	logic signed [14:0] yaw_q;
	logic signed [13:0] pitch_q;
	// Scratch
	logic [31:0]        dist_q;
	logic [27:0]        wrap_q;
	logic [12:0]        qa_q;
	logic               neg_q;
	logic [30:0]        x_q, x2_q;
	logic [31:0]        p_q;
	logic signed [15:0] trig_q [0:3];
	logic signed [65:0] prod_q;

	// Combinational terms
	logic signed [32:0] op_a, op_b;
	logic signed [15:0] vec_c;
	logic signed [33:0] rnd6;
	logic signed [27:0] dang, yaw_t;
	logic [27:0]        wrap_u;
	logic [12:0]        wq;
	logic [27:0]        wrem;
	logic signed [15:0] yaw_new;
	logic signed [27:0] pitch_t;
	logic signed [13:0] pitch_new;
	logic signed [16:0] ang, ared;
	logic [12:0]        qa_d;
	logic               neg_d;
	logic [7:0]         qq;
	logic [12:0]        rr13;
	logic [30:0]        x_d;
	logic [31:0]        rsum;
	logic [15:0]        rmag;
	logic signed [15:0] sin_d;
	logic signed [47:0] psum;
	logic signed [35:0] step, step_s, pos_sum;
	logic [1:0]         axis;
	logic signed [31:0] pos_new;
	logic signed [35:0] vert_sum;
	logic signed [31:0] vert_new;
	logic signed [33:0] dsum;
	logic signed [15:0] dir_r;
	logic               back;

	function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
		logic signed [31:0] r;
		if (v > 36'sd2147483647) r = 32'sh7FFFFFFF;
		else if (v < -36'sd2147483648) r = 32'sh80000000;
		else r = v[31:0];
		return r;
	endfunction

	function automatic logic signed [15:0] neg_d_sel(input logic n, input logic [15:0] m);
		logic signed [15:0] r;
		r = n ? -$signed(m) : $signed(m);
		return r;
	endfunction

	assign stat.mode     = mode_q;
	assign stat.move_dir = dir_q;
	assign st.pos_x      = pos_q[0];
	assign st.pos_y      = pos_q[1];
	assign st.pos_z      = pos_q[2];
	assign st.dir_x      = vdir_q[0];
	assign st.dir_y      = vdir_q[1];
	assign st.dir_z      = vdir_q[2];
	assign st.yaw_deg    = yaw_q;
	assign st.pitch_deg  = pitch_q;

	assign axis = cmd.idx;
	assign back = (dir_q == fcu_pkg::MV_BACKWARD) || (dir_q == fcu_pkg::MV_LEFT) ||
		(dir_q == fcu_pkg::MV_DOWN);

	// Write config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q <= 16'd256;
			gain_q  <= 16'd410;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fcu_pkg::REG_MOVE_SPEED: speed_q <= cfg_data;
				fcu_pkg::REG_LOOK_GAIN:  gain_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Latch the request
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q    <= in_mode;
			dir_q     <= in_move_dir;
			elapsed_q <= in_elapsed_ms;
			dx_q      <= in_mouse_dx;
			dy_q      <= in_mouse_dy;
		end
	end

	// Select the vector component for a position step
	always_comb begin
		vec_c = 16'sd0;
		if (dir_q == fcu_pkg::MV_RIGHT || dir_q == fcu_pkg::MV_LEFT) begin
			if (axis == 2'd0) vec_c = -trig_q[fcu_pkg::TRIG_SY];
			else if (axis == 2'd2) vec_c = trig_q[fcu_pkg::TRIG_CY];
		end else if (axis != 2'd3) begin
			vec_c = vdir_q[axis];
		end
	end

	// Multiplier operands
	always_comb begin
		op_a = 33'sd0;
		op_b = 33'sd0;
		case (cmd.mul_sel)
			fcu_pkg::MUL_DIST: begin
				op_a = $signed({17'd0, elapsed_q});
				op_b = $signed({17'd0, speed_q});
			end
			fcu_pkg::MUL_DYAW: begin
				op_a = {{17{dx_q[15]}}, dx_q};
				op_b = $signed({17'd0, gain_q});
			end
			fcu_pkg::MUL_DPITCH: begin
				op_a = {{17{dy_q[15]}}, dy_q};
				op_b = $signed({17'd0, gain_q});
			end
			fcu_pkg::MUL_WRAP: begin
				op_a = $signed({14'd0, wrap_q[27:9]});
				op_b = $signed({13'd0, fcu_pkg::WRAP_RECIP});
			end
			fcu_pkg::MUL_QUOT: begin
				op_a = $signed({20'd0, qa_q});
				op_b = $signed({18'd0, fcu_pkg::QUOT_RECIP});
			end
			fcu_pkg::MUL_XX: begin
				op_a = $signed({2'd0, x_q});
				op_b = $signed({2'd0, x_q});
			end
			fcu_pkg::MUL_HORNER: begin
				op_a = $signed({1'b0, p_q});
				op_b = $signed({2'd0, x2_q});
			end
			fcu_pkg::MUL_XP: begin
				op_a = $signed({2'd0, x_q});
				op_b = $signed({1'b0, p_q});
			end
			fcu_pkg::MUL_STEP: begin
				op_a = $signed({1'b0, dist_q});
				op_b = {{17{vec_c[15]}}, vec_c};
			end
			fcu_pkg::MUL_DIR0: begin
				op_a = {{17{trig_q[fcu_pkg::TRIG_CY][15]}}, trig_q[fcu_pkg::TRIG_CY]};
				op_b = {{17{trig_q[fcu_pkg::TRIG_CP][15]}}, trig_q[fcu_pkg::TRIG_CP]};
			end
			fcu_pkg::MUL_DIR2: begin
				op_a = {{17{trig_q[fcu_pkg::TRIG_SY][15]}}, trig_q[fcu_pkg::TRIG_SY]};
				op_b = {{17{trig_q[fcu_pkg::TRIG_CP][15]}}, trig_q[fcu_pkg::TRIG_CP]};
			end
			default: ;
		endcase
	end

	// Register the product
	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;
	end

	// Angle delta, yaw wrap and pitch clamp
	always_comb begin
		rnd6    = prod_q[33:0] + 34'sd32;
		dang    = rnd6[33:6];
		yaw_t   = {{13{yaw_q[14]}}, yaw_q} + dang + 28'sd11520;
		wrap_u  = $unsigned(yaw_t) + fcu_pkg::WRAP_OFFSET;
		wq      = prod_q[37:25];
		wrem    = wrap_q - 28'(wq) * 28'd23040;
		yaw_new = $signed({1'b0, wrem[14:0]}) - 16'sd11520;
		pitch_t = {{14{pitch_q[13]}}, pitch_q} - dang;
		if (pitch_t > 28'sd5696) pitch_new = 14'sd5696;
		else if (pitch_t < -28'sd5696) pitch_new = -14'sd5696;
		else pitch_new = pitch_t[13:0];
	end

	// Reduce an angle to a quarter wave and its sign
	always_comb begin
		case (cmd.idx)
			fcu_pkg::TRIG_SY: ang = {{2{yaw_q[14]}}, yaw_q};
			fcu_pkg::TRIG_CY: ang = {{2{yaw_q[14]}}, yaw_q} + 17'sd5760;
			fcu_pkg::TRIG_SP: ang = {{3{pitch_q[13]}}, pitch_q};
			default:          ang = {{3{pitch_q[13]}}, pitch_q} + 17'sd5760;
		endcase
		ared = (ang < 17'sd0) ? ang + 17'sd23040 : ang;
		if (ared <= 17'sd5760) begin
			qa_d  = ared[12:0];
			neg_d = 1'b0;
		end else if (ared <= 17'sd11520) begin
			qa_d  = 13'(17'sd11520 - ared);
			neg_d = 1'b0;
		end else if (ared <= 17'sd17280) begin
			qa_d  = 13'(ared - 17'sd11520);
			neg_d = 1'b1;
		end else begin
			qa_d  = 13'(17'sd23040 - ared);
			neg_d = 1'b1;
		end
	end

	// Series input and output conditioning
	always_comb begin
		qq    = prod_q[27:20];
		rr13  = qa_q - 13'(qq) * 13'd45;
		x_d   = {qq, 23'd0} + {8'd0, fcu_pkg::XFRAC[rr13[5:0]]};
		rsum  = {1'b0, prod_q[60:30]} + 32'd32768;
		rmag  = (rsum[31:16] > 16'd16384) ? 16'd16384 : rsum[31:16];
		sin_d = neg_d_sel(neg_q, rmag);
	end

	// Position step and direction rounding
	always_comb begin
		psum     = prod_q[47:0] + 48'sd8192;
		step     = {{2{psum[47]}}, psum[47:14]};
		step_s   = back ? -step : step;
		pos_sum  = {{4{pos_q[axis][31]}}, pos_q[axis]} + step_s;
		pos_new  = sat32(pos_sum);
		vert_sum = {{4{pos_q[1][31]}}, pos_q[1]} +
			(back ? -$signed({4'd0, dist_q}) : $signed({4'd0, dist_q}));
		vert_new = sat32(vert_sum);
		dsum     = prod_q[33:0] + 34'sd8192;
		dir_r    = dsum[29:14];
	end

	// Update camera state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q[0]  <= 32'sd0;
			pos_q[1]  <= 32'sd0;
			pos_q[2]  <= 32'sd0;
			vdir_q[0] <= 16'sd16384;
			vdir_q[1] <= 16'sd0;
			vdir_q[2] <= 16'sd0;
			yaw_q     <= 15'sd0;
			pitch_q   <= 14'sd0;
		end else begin
			case (cmd.wb_sel)
				fcu_pkg::WB_WRAP:  yaw_q   <= yaw_new[14:0];
				fcu_pkg::WB_PITCH: pitch_q <= pitch_new;
				fcu_pkg::WB_STEP:  pos_q[axis] <= pos_new;
				fcu_pkg::WB_VERT:  pos_q[1] <= vert_new;
				fcu_pkg::WB_DIR0: begin
					vdir_q[0] <= dir_r;
					vdir_q[1] <= trig_q[fcu_pkg::TRIG_SP];
				end
				fcu_pkg::WB_DIR2:  vdir_q[2] <= dir_r;
				default: ;
			endcase
		end
	end

	// Update scratch registers
	always_ff @(posedge clk) begin
		case (cmd.wb_sel)
			fcu_pkg::WB_DIST:   dist_q <= prod_q[31:0];
			fcu_pkg::WB_YAW:    wrap_q <= wrap_u;
			fcu_pkg::WB_SLOAD: begin
				qa_q  <= qa_d;
				neg_q <= neg_d;
			end
			fcu_pkg::WB_QUOT:   x_q <= x_d;
			fcu_pkg::WB_X2: begin
				x2_q <= prod_q[60:30];
				p_q  <= fcu_pkg::C9;
			end
			fcu_pkg::WB_HORNER: p_q <= fcu_pkg::hcoef(cmd.idx) - prod_q[61:30];
			fcu_pkg::WB_SIN:    trig_q[cmd.idx] <= sin_d;
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// ===== src/fly_camera_update.sv =====
// Work per request: none for an unused move code, a distance and a vertical step for
// up/down, a distance and three axis steps for forward/backward, plus two sine evaluations
// for right/left, and four sine evaluations for look; a stalled output register delays it.
// One request at a time: the next request is taken once the result has entered the
// output register. One shared 33x33 multiplier serves all the steps in turn.
// Reset: asynchronous, active low.
// ----------------------------------------------------------------------------
// fly_camera_update: first-person fly camera state update
// Streams move and look requests and returns the new camera state for each.
// ----------------------------------------------------------------------------
`default_nettype none

module fly_camera_update (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// Config write
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic         cfg_index,
	input  wire logic [15:0]  cfg_data,
	// Request stream
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [55:0]  s_tdata,  // move_dir[2:0], elapsed_ms[18:3],
	                                    // mouse_dx[34:19], mouse_dy[50:35], zero pad
	input  wire logic         s_tuser,  // mode
	// Result stream
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [175:0]      m_tdata   // pos_x, pos_y, pos_z, dir_x, dir_y, dir_z,
	                                    // yaw_deg, pitch_deg, zero pad
);

	fcu_pkg::fcu_cmd_t   cmd;
	fcu_pkg::fcu_stat_t  stat;
	fcu_pkg::fcu_state_t st;
	logic                out_free;
	logic                m_valid_q;
	logic [175:0]        m_data_q;

	assign cfg_ready = 1'b1;
	assign out_free  = !m_valid_q || m_tready;
	assign m_tvalid  = m_valid_q;
	assign m_tdata   = m_data_q;

	fcu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.out_free (out_free),
		.stat     (stat),
		.cmd      (cmd)
	);

	fcu_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_mode       (s_tuser),
		.in_move_dir   (s_tdata[2:0]),
		.in_elapsed_ms (s_tdata[18:3]),
		.in_mouse_dx   (s_tdata[34:19]),
		.in_mouse_dy   (s_tdata[50:35]),
		.cmd           (cmd),
		.stat          (stat),
		.st            (st)
	);

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.publish) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			m_data_q <= {3'd0, st.pitch_deg, st.yaw_deg, st.dir_z, st.dir_y, st.dir_x,
				st.pos_z, st.pos_y, st.pos_x};
		end
	end

`ifndef SYNTHESIS
	a_publish_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |=> m_tvalid)
		else $error("result not presented after publish");

	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st.pitch_deg <= 14'sd5696) && (st.pitch_deg >= -14'sd5696))
		else $error("pitch out of clamp range");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |-> !s_tready)
		else $error("request taken while result pending");
`endif

endmodule

`default_nettype wire
